[rtl/core/nnr_pkg.sv]
package nnr_pkg;

  localparam int POS_W     = 10;
  localparam int PIX_W     = 8;
  localparam int DIM_W     = 11;
  localparam int COEF_W    = 16;
  localparam int OFS_W     = 12;
  localparam int PROD_W    = OFS_W + COEF_W;
  localparam int CFG_IDX_W = 2;
  localparam int TDATA_W   = 32;

  localparam logic [DIM_W-1:0]         WIDTH_RST  = 11'd1024;
  localparam logic [DIM_W-1:0]         HEIGHT_RST = 11'd1024;
  localparam logic signed [COEF_W-1:0] COS_RST    = 16'sd16384;
  localparam logic signed [COEF_W-1:0] SIN_RST    = 16'sd0;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_FETCH = 1'b1
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_COS_ANGLE    = 2'd2,
    CFG_SIN_ANGLE    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    func_t             func;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [PIX_W-1:0]  pix;
  } item_t;

endpackage

[rtl/core/nearest_neighbor_rotation_top.sv]
// Fetch results pass through the map pipeline and the frame store read stage.
// Throughput: one transaction per cycle on either side unless out_tready holds a result back; loads return nothing.
// The map pipeline has 3 stages, then one frame store read stage.
// Reset clears all valid flags and restores the configuration registers.
// The frame store is not cleared: a pixel reads back undefined until loaded.
module nearest_neighbor_rotation_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int FRAC_BITS  = 14
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // pos_x[9:0], pos_y[19:10], pixel_in[27:20], zero fill
  input  logic [nnr_pkg::TDATA_W-1:0]       in_tdata,
  // func
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // pixel_out[7:0], out_x[17:8], out_y[27:18], zero fill
  output logic [nnr_pkg::TDATA_W-1:0]       out_tdata,
  // in_bounds
  output logic                              out_tuser,
  input  logic                              cfg_we,
  input  logic [nnr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nnr_pkg::COEF_W-1:0]        cfg_wdata
);
  import nnr_pkg::*;

  localparam int SUM_W = ((PROD_W > 12 + FRAC_BITS) ? PROD_W : 12 + FRAC_BITS) + 2;
  localparam int QW    = SUM_W - FRAC_BITS - 1;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  logic [DIM_W-1:0]         width_r, height_r, w_eff, h_eff;
  logic signed [COEF_W-1:0] cos_r, sin_r;

  item_t                   in_item, m_item;
  logic                    m_valid, m_ready;
  logic signed [SUM_W-1:0] m_sx, m_sy;

  logic          ld5, v5_r, inb_r;
  logic [POS_W-1:0] ox_r, oy_r;

  logic          neg_x, neg_y, in_x, in_y, hit, load_ok, is_load;
  logic [QW-1:0] qx, qy, col, row;
  logic          ram_en, ram_we;
  logic [AW-1:0] ram_addr, rd_addr, wr_addr;
  logic [PIX_W-1:0] ram_rdata, pixel_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      cos_r    <= COS_RST;
      sin_r    <= SIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_wdata[DIM_W-1:0];
        CFG_COS_ANGLE:    cos_r    <= $signed(cfg_wdata);
        CFG_SIN_ANGLE:    sin_r    <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign w_eff = (32'(width_r) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : width_r;
  assign h_eff = (32'(height_r) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : height_r;

  assign in_item.func = func_t'(in_tuser);
  assign in_item.x    = in_tdata[POS_W-1:0];
  assign in_item.y    = in_tdata[2*POS_W-1:POS_W];
  assign in_item.pix  = in_tdata[2*POS_W+PIX_W-1:2*POS_W];

  nnr_map #(
    .FRAC_BITS (FRAC_BITS),
    .SUM_W     (SUM_W)
  ) u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_tvalid),
    .s_ready (in_tready),
    .s_item  (in_item),
    .dim_w   (w_eff),
    .dim_h   (h_eff),
    .cos_q   (cos_r),
    .sin_q   (sin_r),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item),
    .m_sx    (m_sx),
    .m_sy    (m_sy)
  );

  // truncate toward zero, then check the frame bounds
  assign neg_x = m_sx[SUM_W-1];
  assign neg_y = m_sy[SUM_W-1];
  assign qx    = m_sx[SUM_W-1:FRAC_BITS+1];
  assign qy    = m_sy[SUM_W-1:FRAC_BITS+1];
  assign in_x  = neg_x ? ((&qx) && (|m_sx[FRAC_BITS:0]) && (w_eff != '0))
                       : (qx < QW'(w_eff));
  assign in_y  = neg_y ? ((&qy) && (|m_sy[FRAC_BITS:0]) && (h_eff != '0))
                       : (qy < QW'(h_eff));
  assign hit    = in_x && in_y;
  assign col    = neg_x ? '0 : qx;
  assign row    = neg_y ? '0 : qy;

  assign rd_addr = hit ? (AW'(row) * AW'(MAX_WIDTH) + AW'(col)) : '0;
  assign wr_addr = AW'(m_item.y) * AW'(MAX_WIDTH) + AW'(m_item.x);
  assign load_ok = (32'(m_item.x) < MAX_WIDTH) && (32'(m_item.y) < MAX_HEIGHT);
  assign is_load = (m_item.func == FUNC_LOAD);

  assign ld5     = !v5_r || out_tready;
  assign m_ready = is_load || ld5;

  assign ram_we   = is_load;
  assign ram_en   = m_valid && (is_load ? load_ok : ld5);
  assign ram_addr = is_load ? wr_addr : rd_addr;

  nnr_ram #(
    .DATA_W (PIX_W),
    .DEPTH  (DEPTH)
  ) u_frame (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (m_item.pix),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (ld5) begin
      v5_r <= m_valid && !is_load;
    end
  end

  always_ff @(posedge clk) begin
    if (ld5 && m_valid && !is_load) begin
      inb_r <= hit;
      ox_r  <= m_item.x;
      oy_r  <= m_item.y;
    end
  end

  assign pixel_out  = inb_r ? ram_rdata : '0;
  assign out_tvalid = v5_r;
  assign out_tuser  = inb_r;
  assign out_tdata  = TDATA_W'({oy_r, ox_r, pixel_out});

  a_hold_rdata: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && !out_tready |=> $stable(ram_rdata))
    else $error("frame store read data changed under a stalled result");

  a_fetch_lands: assert property (@(posedge clk) disable iff (!rst_n)
    m_valid && !is_load && ld5 |=> v5_r)
    else $error("fetch left the map pipeline without a result");

  a_load_drains: assert property (@(posedge clk) disable iff (!rst_n)
    m_valid && is_load |=> !(ram_en && ram_we && $past(ram_en && ram_we)
                            && (ram_addr == $past(ram_addr)) && !m_valid))
    else $error("load retired twice");

endmodule

[rtl/core/nnr_ram.sv]
module nnr_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DATA_W-1:0]        wdata,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[rtl/core/nnr_map.sv]
module nnr_map #(
  parameter int FRAC_BITS = 14,
  parameter int SUM_W     = 30
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                s_valid,
  output logic                                s_ready,
  input  nnr_pkg::item_t                      s_item,
  input  logic [nnr_pkg::DIM_W-1:0]           dim_w,
  input  logic [nnr_pkg::DIM_W-1:0]           dim_h,
  input  logic signed [nnr_pkg::COEF_W-1:0]   cos_q,
  input  logic signed [nnr_pkg::COEF_W-1:0]   sin_q,
  output logic                                m_valid,
  input  logic                                m_ready,
  output nnr_pkg::item_t                      m_item,
  output logic signed [SUM_W-1:0]             m_sx,
  output logic signed [SUM_W-1:0]             m_sy
);
  import nnr_pkg::*;

  logic v1_r, v2_r, v3_r;
  logic ld1, ld2, ld3;

  item_t item1_r, item2_r, item3_r;
  logic signed [OFS_W-1:0]  ox1_r, oy1_r, ox_nxt, oy_nxt;
  logic signed [PROD_W-1:0] pxc_r, pys_r, pxs_r, pyc_r;
  logic signed [SUM_W-1:0]  sx_r, sy_r, sx_nxt, sy_nxt, bias_x, bias_y;

  assign ld3     = !v3_r || m_ready;
  assign ld2     = !v2_r || ld3;
  assign ld1     = !v1_r || ld2;
  assign s_ready = ld1;

  assign ox_nxt = $signed({1'b0, s_item.x, 1'b0}) - $signed({1'b0, dim_w});
  assign oy_nxt = $signed({1'b0, s_item.y, 1'b0}) - $signed({1'b0, dim_h});

  assign bias_x = $signed(SUM_W'({1'b0, dim_w} + 12'd1) << FRAC_BITS);
  assign bias_y = $signed(SUM_W'({1'b0, dim_h} + 12'd1) << FRAC_BITS);
  assign sx_nxt = SUM_W'(pxc_r) - SUM_W'(pys_r) + bias_x;
  assign sy_nxt = SUM_W'(pxs_r) + SUM_W'(pyc_r) + bias_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= s_valid;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      item1_r <= s_item;
      ox1_r   <= ox_nxt;
      oy1_r   <= oy_nxt;
    end
    if (ld2) begin
      item2_r <= item1_r;
      pxc_r   <= ox1_r * cos_q;
      pys_r   <= oy1_r * sin_q;
      pxs_r   <= ox1_r * sin_q;
      pyc_r   <= oy1_r * cos_q;
    end
    if (ld3) begin
      item3_r <= item2_r;
      sx_r    <= sx_nxt;
      sy_r    <= sy_nxt;
    end
  end

  assign m_valid = v3_r;
  assign m_item  = item3_r;
  assign m_sx    = sx_r;
  assign m_sy    = sy_r;

endmodule
